[design/dbs_pkg.sv]
package dbs_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_CONTAINS   = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic remove;
  } cell_ctrl_t;

endpackage

[design/dbs_cell.sv]
module dbs_cell
  import dbs_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [CW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic [DATA_WIDTH-1:0] right_val,
  input  logic                  prefix_in,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic                  prefix_out
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [DATA_WIDTH-1:0] slot_r;
  logic [DATA_WIDTH-1:0] slot_nxt;
  logic                  occupied;
  logic                  hit;

  assign occupied   = IDX < count;
  assign hit        = occupied && (slot_r == key);
  assign prefix_out = prefix_in | hit;
  assign val_o      = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.push_front) begin
      slot_nxt = left_val;
    end else if (ctrl.push_back) begin
      if (IDX == count) slot_nxt = key;
    end else if (ctrl.pop_front) begin
      slot_nxt = right_val;
    end else if (ctrl.remove && prefix_out) begin
      slot_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

[design/deque_bag_store.sv]
// Bounded double-ended queue with search, held in a row of DEPTH cells,
// front in cell 0. Every command (push or pop at either end, contains,
// remove first match) gives one result describing the store afterwards.
// The cell row compares, shifts and compacts in the cycle of the transfer,
// and the next cycle reads front, back and a value popped from the back
// out of the updated row into the output register; a value popped from
// the front is registered at the transfer. A new command is taken no
// earlier than the cycle in which the previous result is handed on, so
// commands never overlap. Input is stalled during reset.
module deque_bag_store
  import dbs_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value,
  output logic signed [31:0] out_popped_value,
  output logic [CW-1:0]      out_fill_count,
  output logic               out_is_empty
);

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [31:0] to_field(input logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] sv;
    logic signed [63:0]           w;
    sv = v;
    w  = 64'(sv);
    return w[31:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic [DATA_WIDTH-1:0] popped_r;
  logic                  popf_ok_r, popb_ok_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic                  out_found_r;
  logic [31:0]           out_front_r, out_back_r, out_popped_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_empty_r;

  logic                  accept;
  logic                  full, empty;
  logic [63:0]           in_ext;
  logic [DATA_WIDTH-1:0] key;
  cell_ctrl_t            ctrl;
  logic                  popf_ok, popb_ok, any_match;
  logic [DATA_WIDTH-1:0] vals [DEPTH];
  logic                  pre  [DEPTH+1];
  logic [DATA_WIDTH-1:0] back_v, popb_v;

  assign accept = in_valid && !in_stall;
  assign full   = count_r == DEPTH_C;
  assign empty  = count_r == '0;
  assign in_ext = 64'(in_item_value);
  assign key    = in_ext[DATA_WIDTH-1:0];

  assign ctrl.push_front = accept && (in_cmd == CMD_PUSH_FRONT) && !full;
  assign ctrl.push_back  = accept && (in_cmd == CMD_PUSH_BACK) && !full;
  assign ctrl.pop_front  = accept && (in_cmd == CMD_POP_FRONT) && !empty;
  assign ctrl.remove     = accept && (in_cmd == CMD_REMOVE);
  assign popf_ok         = ctrl.pop_front;
  assign popb_ok         = accept && (in_cmd == CMD_POP_BACK) && !empty;
  assign any_match       = pre[DEPTH];

  assign pre[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = key;
    end else begin : g_mid_l
      assign left_v = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[g+1];
    end
    dbs_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .key        (key),
      .left_val   (left_v),
      .right_val  (right_v),
      .prefix_in  (pre[g]),
      .val_o      (vals[g]),
      .prefix_out (pre[g+1])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    found_nxt  = 1'b0;
    case (in_cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) status_nxt = STATUS_OVERFLOW;
        else      count_nxt  = count_r + CW'(1);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) status_nxt = STATUS_UNDERFLOW;
        else       count_nxt  = count_r - CW'(1);
      end
      CMD_CONTAINS: begin
        found_nxt = any_match;
      end
      CMD_REMOVE: begin
        found_nxt = any_match;
        if (any_match) count_nxt = count_r - CW'(1);
      end
      default: ;
    endcase
  end

  // back after the update, and the old back for a pop from the back
  always_comb begin
    back_v = '0;
    popb_v = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == count_r - CW'(1)) back_v |= vals[i];
      if (CW'(i) == count_r)          popb_v |= vals[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = !rst_n || (out_valid_r && out_stall);
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) count_r <= count_nxt;
      if (state_r == ST_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      popf_ok_r <= popf_ok;
      popb_ok_r <= popb_ok;
      popped_r  <= vals[0];
    end
    if (state_r == ST_FIN) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_front_r  <= empty ? 32'd0 : to_field(vals[0]);
      out_back_r   <= empty ? 32'd0 : to_field(back_v);
      if (popf_ok_r)      out_popped_r <= to_field(popped_r);
      else if (popb_ok_r) out_popped_r <= to_field(popb_v);
      else                out_popped_r <= 32'd0;
      out_count_r  <= count_r;
      out_empty_r  <= empty;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_popped_value = out_popped_r;
  assign out_fill_count   = out_count_r;
  assign out_is_empty     = out_empty_r;

endmodule
